>>> rtl/core/dual_lane_byte_hash_top_defines.svh
// ----------------------------------------------------------------------------
// dual_lane_byte_hash_top_defines.svh
// Assertion macros used by the checker of the dual-lane byte hash.
// ----------------------------------------------------------------------------
`ifndef DUAL_LANE_BYTE_HASH_TOP_DEFINES_SVH
`define DUAL_LANE_BYTE_HASH_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define DLBH_ASSERT_SAME(label, clk, rst_n, ante, cons, text) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(text);

// Check that cons holds in the cycle after ante.
`define DLBH_ASSERT_NEXT(label, clk, rst_n, ante, cons, text) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(text);

`endif

>>> rtl/core/dlbh_pkg.sv
// ----------------------------------------------------------------------------
// dlbh_pkg
// Widths and fixed constants of the dual-lane byte hash.
// ----------------------------------------------------------------------------
package dlbh_pkg;

	localparam int LANE_W = 64;
	localparam int HALF_W = 32;
	localparam int BYTE_W = 8;

	// Rotation amounts of the two lanes
	localparam int ROT_UPPER = 13;
	localparam int ROT_LOWER = 17;

	// Lane offsets loaded at reset and on a first item
	localparam logic [LANE_W-1:0] OFFSET_UPPER = 64'd1469598103934665603;
	localparam logic [LANE_W-1:0] OFFSET_LOWER = 64'd1099511628211;

	// Lane multipliers
	localparam logic [LANE_W-1:0] PRIME_UPPER = 64'd1099511628211;
	localparam logic [LANE_W-1:0] PRIME_LOWER = 64'd14029467366897019727;

	typedef logic [LANE_W-1:0] lane_t;
	typedef logic [BYTE_W-1:0] byte_t;

endpackage

>>> rtl/core/dlbh_if.sv
// ----------------------------------------------------------------------------
// dlbh_if
// Valid/ready channels of the dual-lane byte hash: message items in,
// digest items out.
// ----------------------------------------------------------------------------
interface dlbh_msg_if
	import dlbh_pkg::*;
	;
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  byte_valid;
	logic  first_item;
	logic  last_item;

	modport source (output valid, output data_byte, output byte_valid,
		output first_item, output last_item, input ready);
	modport sink (input valid, input data_byte, input byte_valid,
		input first_item, input last_item, output ready);
endinterface

interface dlbh_digest_if
	import dlbh_pkg::*;
	;
	logic  valid;
	logic  ready;
	lane_t digest_upper;
	lane_t digest_lower;

	modport source (output valid, output digest_upper, output digest_lower, input ready);
	modport sink (input valid, input digest_upper, input digest_lower, output ready);
endinterface

>>> rtl/core/dual_lane_byte_hash_top.sv
// ----------------------------------------------------------------------------
// dual_lane_byte_hash_top
// 128-bit byte-stream hash kept as two 64-bit lanes, mixed one byte per item.
// ----------------------------------------------------------------------------
// An item with a valid byte occupies the block from its accept cycle through
// the upper-lane partial products on the shared 32x32 multiplier, the ST_PREP
// step that folds the byte into the lower lane, and the lower-lane partial
// products. Both 64-bit lane products are built from three 32x32 partial
// products, one per cycle, on the single multiplier; that recurrence sets the
// rate. An item without a valid byte skips the mixing. An item marked last
// then enters ST_EMIT, where the digest register is loaded, and stays there
// while an earlier digest has not been taken; the next item is accepted while
// a digest still waits.
module dual_lane_byte_hash_top
	import dlbh_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	dlbh_msg_if.sink      msg,
	dlbh_digest_if.source digest
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_EMIT = 3'd3;

	localparam logic [1:0] PP_LL = 2'd0;
	localparam logic [1:0] PP_LH = 2'd1;
	localparam logic [1:0] PP_HL = 2'd2;

	logic [2:0] state_q;
	logic [1:0] pp_q;
	logic       lane_q;
	logic       last_q;
	logic       out_valid_q;

	lane_t upper_q;
	lane_t lower_q;
	lane_t mul_a_q;
	lane_t acc_q;
	byte_t byte_q;
	lane_t dig_upper_q;
	lane_t dig_lower_q;

	logic              accept;
	logic              emit_load;
	lane_t             base_upper;
	lane_t             mul_k;
	logic [HALF_W-1:0] mul_x;
	logic [HALF_W-1:0] mul_y;
	lane_t             prod;
	logic [HALF_W-1:0] hi_sum;
	lane_t             mul_res;
	lane_t             lower_sum;
	lane_t             lower_mix;

	assign accept    = msg.valid && msg.ready;
	assign msg.ready = (state_q == ST_IDLE);
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || digest.ready);

	// Pick the upper lane start: offset on a first item
	assign base_upper = msg.first_item ? OFFSET_UPPER : upper_q;

	// Select the halves for the current partial product
	assign mul_k = lane_q ? PRIME_LOWER : PRIME_UPPER;
	always_comb begin
		unique case (pp_q)
			PP_LL: begin
				mul_x = mul_a_q[HALF_W-1:0];
				mul_y = mul_k[HALF_W-1:0];
			end
			PP_LH: begin
				mul_x = mul_a_q[HALF_W-1:0];
				mul_y = mul_k[LANE_W-1:HALF_W];
			end
			PP_HL: begin
				mul_x = mul_a_q[LANE_W-1:HALF_W];
				mul_y = mul_k[HALF_W-1:0];
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end

	// Shared 32x32 multiplier and the high-half accumulate
	assign prod    = LANE_W'(mul_x) * LANE_W'(mul_y);
	assign hi_sum  = acc_q[LANE_W-1:HALF_W] + prod[HALF_W-1:0];
	assign mul_res = {hi_sum, acc_q[HALF_W-1:0]};

	// Fold the byte and the new upper lane's low byte into the lower lane
	assign lower_sum = lower_q + LANE_W'(byte_q) + LANE_W'(upper_q[BYTE_W-1:0]);
	assign lower_mix = lower_sum ^ ((lower_sum << ROT_LOWER) |
		(lower_sum >> (LANE_W - ROT_LOWER)));

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pp_q    <= PP_LL;
			lane_q  <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= msg.last_item;
						pp_q   <= PP_LL;
						lane_q <= 1'b0;
						if (msg.byte_valid) begin
							state_q <= ST_MUL;
						end else if (msg.last_item) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_MUL: begin
					unique case (pp_q)
						PP_LL:   pp_q <= PP_LH;
						PP_LH:   pp_q <= PP_HL;
						default: begin
							pp_q <= PP_LL;
							if (!lane_q) begin
								state_q <= ST_PREP;
							end else begin
								state_q <= last_q ? ST_EMIT : ST_IDLE;
							end
						end
					endcase
				end
				ST_PREP: begin
					lane_q  <= 1'b1;
					state_q <= ST_MUL;
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Lane state: reload on a first item, update at the last partial product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= OFFSET_UPPER;
			lower_q <= OFFSET_LOWER;
		end else if (accept && msg.first_item) begin
			upper_q <= OFFSET_UPPER;
			lower_q <= OFFSET_LOWER;
		end else if (state_q == ST_MUL && pp_q == PP_HL) begin
			if (!lane_q) begin
				upper_q <= (mul_res << ROT_UPPER) | (mul_res >> (LANE_W - ROT_UPPER));
			end else begin
				lower_q <= mul_res;
			end
		end
	end

	// Operand, accumulator and byte registers
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q  <= msg.data_byte;
			mul_a_q <= base_upper ^ LANE_W'(msg.data_byte);
		end else if (state_q == ST_PREP) begin
			mul_a_q <= lower_mix;
		end
		if (state_q == ST_MUL) begin
			if (pp_q == PP_LL) begin
				acc_q <= prod;
			end else begin
				acc_q[LANE_W-1:HALF_W] <= hi_sum;
			end
		end
	end

	// Digest output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (digest.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			dig_upper_q <= upper_q;
			dig_lower_q <= lower_q;
		end
	end

	assign digest.valid        = out_valid_q;
	assign digest.digest_upper = dig_upper_q;
	assign digest.digest_lower = dig_lower_q;

endmodule

>>> rtl/core/dlbh_checker.sv
// ----------------------------------------------------------------------------
// dlbh_checker
// Port-level checks of the dual-lane byte hash, bound to the top level.
// ----------------------------------------------------------------------------
`include "dual_lane_byte_hash_top_defines.svh"

module dlbh_checker
	import dlbh_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  msg_valid,
	input logic  msg_ready,
	input logic  msg_byte_valid,
	input logic  msg_last_item,
	input logic  digest_valid,
	input logic  digest_ready,
	input lane_t digest_upper,
	input lane_t digest_lower
);

	// A stalled digest item stays offered
	`DLBH_ASSERT_NEXT(a_digest_hold, clk, arst_n, digest_valid && !digest_ready, digest_valid, "digest item dropped while stalled")

	// A stalled digest item keeps its value
	`DLBH_ASSERT_NEXT(a_digest_stable, clk, arst_n, digest_valid && !digest_ready, $stable(digest_upper) && $stable(digest_lower), "digest payload changed while stalled")

	// An accepted item with a byte or a last mark keeps the next one out in the cycle after
	`DLBH_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, msg_valid && msg_ready && (msg_byte_valid || msg_last_item), !msg_ready, "item accepted while the previous one is in work")

	// A digest never appears in the cycle right after an accept
	`DLBH_ASSERT_NEXT(a_no_early_digest, clk, arst_n, msg_valid && msg_ready, !$rose(digest_valid), "digest raised too early after an item")

endmodule

bind dual_lane_byte_hash_top dlbh_checker u_dlbh_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.msg_valid      (msg.valid),
	.msg_ready      (msg.ready),
	.msg_byte_valid (msg.byte_valid),
	.msg_last_item  (msg.last_item),
	.digest_valid   (digest.valid),
	.digest_ready   (digest.ready),
	.digest_upper   (digest.digest_upper),
	.digest_lower   (digest.digest_lower)
);

>>> test/dual_lane_byte_hash_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_lane_byte_hash_top_tb
// Self-checking bench for the dual-lane byte hash. A queue of message items
// (directed corner cases, then random messages mixed with noise) feeds a
// valid/ready driver. Every accepted item updates a local copy of both hash
// lanes, and each marked-last item queues the expected digest. A monitor
// compares each accepted digest against that queue. Both channels idle at
// random, the digest side holds off once for a long stretch, and the sender
// drains all pending digests a few times.
// ----------------------------------------------------------------------------
module dual_lane_byte_hash_top_tb;
	import dlbh_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned RANDOM_ITEMS = 550;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned HOLD_AFTER   = 30;
	localparam int unsigned TAIL_CYCLES  = 20;

	typedef struct {
		byte_t       data_byte;
		logic        byte_valid;
		logic        first_item;
		logic        last_item;
		int unsigned gap;
		bit          drain;
	} msg_item_t;

	typedef struct {
		lane_t upper;
		lane_t lower;
	} digest_t;

	logic clk;
	logic arst_n;

	dlbh_msg_if    msg_ch ();
	dlbh_digest_if digest_ch ();

	dual_lane_byte_hash_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (digest_ch)
	);

	msg_item_t   pending_items[$];
	digest_t     digests_due[$];
	lane_t       lane_upper;
	lane_t       lane_lower;
	msg_item_t   next_item;
	logic        msg_taken;
	bit          gap_loaded;
	int unsigned send_gap;
	int unsigned stall_left;
	int unsigned steady_left;
	bit          long_hold_done;
	int unsigned cycle_count;
	int unsigned items_accepted;
	int unsigned digests_checked;
	int unsigned error_count;

	// Toggle the clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Pick a sender gap: mostly none, some short, a few long
	function automatic int unsigned sender_gap(input bit steady);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Pick a receiver stall: mostly short, a few long
	function automatic int unsigned receiver_stall();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 2);
		if (r < 90)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// Append one message item to the send queue
	task automatic queue_item(input byte_t data, input logic valid_byte, input logic first,
		input logic last, input int unsigned gap, input bit drain);
		msg_item_t it;
		it.data_byte  = data;
		it.byte_valid = valid_byte;
		it.first_item = first;
		it.last_item  = last;
		it.gap        = gap;
		it.drain      = drain;
		pending_items.push_back(it);
	endtask

	// Advance both lanes by one accepted item; queue a digest on last
	task automatic absorb_item(input msg_item_t it);
		lane_t   mixed;
		digest_t d;
		if (it.first_item) begin
			lane_upper = OFFSET_UPPER;
			lane_lower = OFFSET_LOWER;
		end
		if (it.byte_valid) begin
			mixed      = (lane_upper ^ lane_t'(it.data_byte)) * PRIME_UPPER;
			lane_upper = {mixed[LANE_W-ROT_UPPER-1:0], mixed[LANE_W-1:LANE_W-ROT_UPPER]};
			mixed      = lane_lower + lane_t'(it.data_byte) + lane_t'(lane_upper[BYTE_W-1:0]);
			mixed      = mixed ^ {mixed[LANE_W-ROT_LOWER-1:0], mixed[LANE_W-1:LANE_W-ROT_LOWER]};
			lane_lower = mixed * PRIME_LOWER;
		end
		if (it.last_item) begin
			d.upper = lane_upper;
			d.lower = lane_lower;
			digests_due.push_back(d);
		end
	endtask

	// Sample both channels: check digests, predict from accepted items
	always @(posedge clk) begin
		if (!arst_n) begin
			msg_taken <= 1'b0;
		end else begin
			msg_taken <= msg_ch.valid && msg_ch.ready;
			if (digest_ch.valid && digest_ch.ready) begin
				if (digests_due.size() == 0) begin
					$error("digest item with none expected: upper %h lower %h",
						digest_ch.digest_upper, digest_ch.digest_lower);
					error_count++;
				end else begin
					digest_t d;
					d = digests_due.pop_front();
					if (digest_ch.digest_upper !== d.upper) begin
						$error("digest_upper: expected %h, got %h", d.upper,
							digest_ch.digest_upper);
						error_count++;
					end
					if (digest_ch.digest_lower !== d.lower) begin
						$error("digest_lower: expected %h, got %h", d.lower,
							digest_ch.digest_lower);
						error_count++;
					end
				end
				digests_checked++;
			end
			if (msg_ch.valid && msg_ch.ready) begin
				next_item.data_byte  = msg_ch.data_byte;
				next_item.byte_valid = msg_ch.byte_valid;
				next_item.first_item = msg_ch.first_item;
				next_item.last_item  = msg_ch.last_item;
				absorb_item(next_item);
				items_accepted++;
			end
		end
	end

	// Drive message items: hold until taken, then gap or offer the next
	always @(negedge clk) begin
		if (!arst_n) begin
			msg_ch.valid <= 1'b0;
		end else if (!msg_ch.valid || msg_taken) begin
			if (!gap_loaded && pending_items.size() != 0) begin
				send_gap   = pending_items[0].gap;
				gap_loaded = 1'b1;
			end
			if (send_gap != 0) begin
				send_gap--;
				msg_ch.valid <= 1'b0;
			end else if (pending_items.size() == 0 ||
					(pending_items[0].drain && digests_due.size() != 0)) begin
				msg_ch.valid <= 1'b0;
			end else begin
				next_item = pending_items.pop_front();
				gap_loaded = 1'b0;
				msg_ch.valid      <= 1'b1;
				msg_ch.data_byte  <= next_item.data_byte;
				msg_ch.byte_valid <= next_item.byte_valid;
				msg_ch.first_item <= next_item.first_item;
				msg_ch.last_item  <= next_item.last_item;
			end
		end
	end

	// Drive digest ready: random stalls, steady stretches, one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			digest_ch.ready <= 1'b0;
		end else begin
			if (!long_hold_done && digests_checked >= HOLD_AFTER) begin
				stall_left     = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (stall_left != 0) begin
				stall_left--;
				digest_ch.ready <= 1'b0;
			end else begin
				digest_ch.ready <= 1'b1;
				if (steady_left != 0) begin
					steady_left--;
				end else begin
					case ($urandom_range(0, 99)) inside
						[0:4]:   steady_left = $urandom_range(40, 150);
						[5:34]:  stall_left = receiver_stall();
						default: ;
					endcase
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d digests still due", cycle_count,
				digests_due.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Build the stimulus, reset, and wait for the run to drain
	initial begin
		int unsigned random_items;
		int unsigned drain_at;
		int unsigned msg_len;
		int unsigned noise_len;
		int unsigned r;
		bit          steady;
		bit          skip_first;
		bit          drain_next;
		logic        valid_byte;
		logic        first;
		logic        last;

		arst_n               = 1'b0;
		msg_ch.valid         = 1'b0;
		msg_ch.data_byte     = '0;
		msg_ch.byte_valid    = 1'b0;
		msg_ch.first_item    = 1'b0;
		msg_ch.last_item     = 1'b0;
		digest_ch.ready      = 1'b0;
		msg_taken            = 1'b0;
		gap_loaded           = 1'b0;
		send_gap             = 0;
		stall_left           = 0;
		steady_left          = 0;
		long_hold_done       = 1'b0;
		cycle_count          = 0;
		items_accepted       = 0;
		digests_checked      = 0;
		error_count          = 0;
		lane_upper           = OFFSET_UPPER;
		lane_lower           = OFFSET_LOWER;

		// Mix into the reset lanes before any first item
		queue_item(8'h00, 1'b1, 1'b0, 1'b1, 0, 1'b0);
		// Empty message emits the offsets
		queue_item(8'h00, 1'b0, 1'b1, 1'b1, 0, 1'b0);
		// Nothing to do: no byte, no flags
		queue_item(8'hA5, 1'b0, 1'b0, 1'b0, 1, 1'b0);
		// Single-byte message of all ones
		queue_item(8'hFF, 1'b1, 1'b1, 1'b1, 0, 1'b0);
		// Keep mixing after a digest without a reload
		queue_item(8'h80, 1'b1, 1'b0, 1'b1, 2, 1'b0);
		// Emit again without mixing
		queue_item(8'h00, 1'b0, 1'b0, 1'b1, 0, 1'b0);
		// Multi-byte message with an empty item inside
		queue_item(8'h01, 1'b1, 1'b1, 1'b0, 0, 1'b0);
		queue_item(8'hFE, 1'b1, 1'b0, 1'b0, 0, 1'b0);
		queue_item(8'h55, 1'b0, 1'b0, 1'b0, 3, 1'b0);
		queue_item(8'hAA, 1'b1, 1'b0, 1'b0, 0, 1'b0);
		queue_item(8'h7F, 1'b1, 1'b0, 1'b1, 0, 1'b0);
		// Reload only, then restart the message mid-stream
		queue_item(8'h3C, 1'b0, 1'b1, 1'b0, 0, 1'b0);
		queue_item(8'hC3, 1'b1, 1'b0, 1'b0, 0, 1'b0);
		queue_item(8'h00, 1'b1, 1'b1, 1'b0, 0, 1'b0);
		queue_item(8'hFF, 1'b1, 1'b0, 1'b1, 0, 1'b0);
		// Reload with no byte, end with no byte: offsets again
		queue_item(8'h10, 1'b0, 1'b1, 1'b0, 0, 1'b0);
		queue_item(8'h20, 1'b0, 1'b0, 1'b1, 0, 1'b0);
		// First and last on one valid byte, back to back
		queue_item(8'h00, 1'b1, 1'b1, 1'b1, 0, 1'b0);
		queue_item(8'h01, 1'b1, 1'b1, 1'b1, 0, 1'b0);

		// Random messages, mostly well formed, with noise between
		random_items = 0;
		drain_at     = 200;
		steady       = 1'b0;
		drain_next   = 1'b1;
		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 20)
				steady = !steady;
			if ($urandom_range(0, 99) < 85) begin
				r = $urandom_range(0, 99);
				if (r < 8)
					msg_len = 0;
				else if (r < 70)
					msg_len = $urandom_range(1, 8);
				else if (r < 95)
					msg_len = $urandom_range(9, 24);
				else
					msg_len = $urandom_range(25, 64);
				skip_first = ($urandom_range(0, 9) == 0);
				if (msg_len == 0) begin
					queue_item(byte_t'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1,
						sender_gap(steady), drain_next);
					drain_next = 1'b0;
					random_items++;
				end
				for (int i = 0; i < msg_len; i++) begin
					if (i > 0 && $urandom_range(0, 19) == 0)
						queue_item(byte_t'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0,
							sender_gap(steady), 1'b0);
					queue_item(byte_t'($urandom_range(0, 255)), 1'b1,
						i == 0 && !skip_first, i == msg_len - 1, sender_gap(steady),
						drain_next);
					drain_next = 1'b0;
					random_items++;
				end
			end else begin
				noise_len = $urandom_range(1, 4);
				for (int i = 0; i < noise_len; i++) begin
					valid_byte = 1'($urandom_range(0, 1));
					first      = 1'($urandom_range(0, 1));
					last       = 1'($urandom_range(0, 1));
					queue_item(byte_t'($urandom_range(0, 255)), valid_byte, first, last,
						sender_gap(steady), drain_next);
					drain_next = 1'b0;
					if (valid_byte || first || last)
						random_items++;
				end
			end
			if (random_items >= drain_at) begin
				drain_next = 1'b1;
				drain_at   = drain_at + 200;
			end
		end

		// Release reset on a falling edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || msg_ch.valid)
			@(negedge clk);
		while (digests_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d message items, checked %0d digests in %0d cycles.",
			items_accepted, digests_checked, cycle_count);
		$display("Covered empty, reload-only and unreloaded messages, a long digest stall"
			, " and drains.");
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
